// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define IAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked on the following edge
`define IAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/iat_pkg.sv -----
// Package for the autocorrelation time core: widths, codes, state types.
// No dependencies.
package iat_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int SAMP_W = 32;
  localparam int TAU_W  = 32;
  localparam int VAR_W  = 48;
  localparam int STAT_W = 2;
  localparam int ACC_W  = 64;
  localparam int CAP_LOG = 40;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD, S_PASS, S_DIVGO, S_DIVW, S_MUL, S_COV, S_EVAL, S_TERM, S_OUT
  } state_t;

  typedef enum logic [2:0] {OP_P, OP_B, OP_C, OP_Q, OP_T} div_op_t;

  function automatic logic [ACC_W-1:0] iat_abs(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] neg;
    neg = -v;
    return v[ACC_W-1] ? neg : v;
  endfunction

endpackage

// ----- rtl/iat_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the autocorrelation time core.
module iat_div #(
  parameter int NW = 80,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW:0]     rem_r, rem_sh, rem_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r, ge;

  always_comb begin
    rem_sh  = {rem_r[DW-1:0], quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        quo_r <= num;
        den_r <= den;
        cnt_r <= CNTW'(NW);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ----- rtl/integrated_autocorrelation_time_core.sv -----
// Integrated autocorrelation time core: sample memory, lag walk, result word.
// Depends on iat_pkg, iat_div and assert_macros.svh.
//
// Usage:
//  Input: a sample word is taken on a rising edge with start high and busy
//  low. Each word is written to the sample memory, so samples stream at one
//  per cycle. Words past MAX_SAMPLES are dropped and flagged.
//  A word with in_last high ends the series; busy then stays high for the
//  lag walk. Each lag t takes a pass over the memory (two read ports),
//  three runs of a shared bit-serial divider for the means, and the
//  MUL and COV steps to form the autocovariance; every lag t >= 1 with a
//  positive autocovariance adds two more runs, for the ratio and the
//  weighting, with the TERM step between them. The walk ends at the first
//  lag whose autocovariance is not positive, or at lag n; after that
//  out_valid rises in the same cycle in which busy falls.
//  Output: one word, out_valid high for one cycle, with tau, variance and
//  status; the receiver cannot stall, so it must take it in that cycle.
//  A series of fewer than two samples skips the lag walk and goes straight
//  to the output state. Reset (synchronous, active low) empties the series;
//  the memory itself is not cleared, only written entries are ever used.
`include "assert_macros.svh"

module integrated_autocorrelation_time_core #(
  parameter int MAX_SAMPLES = iat_pkg::MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = iat_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [iat_pkg::SAMP_W-1:0] in_sample,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic [iat_pkg::TAU_W-1:0]    out_tau_int,
  output logic [iat_pkg::VAR_W-1:0]    out_variance,
  output logic [iat_pkg::STAT_W-1:0]   out_status
);
  import iat_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int NW = ACC_W + FRAC_BITS;
  localparam int QW = CAP_LOG + 1;
  localparam int TW = QW + CW;

  localparam logic [NW-1:0]    CAP_N   = NW'(1) << CAP_LOG;
  localparam logic [ACC_W:0]   TAU_MAX = (ACC_W+1)'(33'h0_FFFF_FFFF);
  localparam logic [ACC_W-1:0] VAR_MAX = ACC_W'(48'hFFFF_FFFF_FFFF);
  localparam logic [ACC_W:0]   HALF    = (ACC_W+1)'(1) << (FRAC_BITS - 1);

  logic [SAMP_W-1:0] mem [MAX_SAMPLES];

  state_t  state_r, state_nxt;
  div_op_t op_r;

  logic [CW-1:0] count_r, t_r, i_r, m_w, rb_full, n_after;
  logic          ovf_r, issue, v1_r, v2_r, accept, store_ok;
  logic [SAMP_W-1:0] rx_r, ry_r, xd_r, yd_r;
  logic signed [ACC_W-1:0] prod_r, pshift, p_r, sb_r, sc_r;
  logic signed [ACC_W-1:0] a_r, b_r, c_r, bc_r, cov_r, var_r, div_res;
  logic signed [ACC_W:0]   psum;
  logic [QW-1:0]  q_r;
  logic [TW-1:0]  term_r;
  logic [ACC_W-1:0] tau_sum_r;
  logic [ACC_W:0]   tau_full;
  logic           div_start, div_done, div_neg, cov_pos;
  logic [NW-1:0]  div_num, div_quo;
  logic [ACC_W-1:0] div_den;

  logic                out_valid_r;
  logic [TAU_W-1:0]    out_tau_r;
  logic [VAR_W-1:0]    out_var_r;
  logic [STAT_W-1:0]   out_stat_r;

  assign busy     = state_r != S_LOAD;
  assign accept   = start && !busy;
  assign store_ok = count_r < CW'(MAX_SAMPLES);
  assign n_after  = store_ok ? count_r + CW'(1) : count_r;
  assign m_w      = count_r - t_r;
  assign rb_full  = i_r + t_r;
  assign issue    = (state_r == S_PASS) && (i_r != m_w);
  assign pshift   = prod_r >>> FRAC_BITS;
  assign psum     = {p_r[ACC_W-1], p_r} + {pshift[ACC_W-1], pshift};
  assign cov_pos  = !cov_r[ACC_W-1] && (cov_r != '0);
  assign tau_full = HALF + {1'b0, tau_sum_r};

  // sample memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[count_r[AW-1:0]] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    rx_r <= mem[i_r[AW-1:0]];
    ry_r <= mem[rb_full[AW-1:0]];
  end

  // divider operand select
  always_comb begin
    div_num = '0;
    div_den = ACC_W'(m_w);
    div_neg = 1'b0;
    unique case (op_r)
      OP_P: begin
        div_num = NW'(iat_abs(p_r));
        div_neg = p_r[ACC_W-1];
      end
      OP_B: begin
        div_num = NW'(iat_abs(sb_r));
        div_neg = sb_r[ACC_W-1];
      end
      OP_C: begin
        div_num = NW'(iat_abs(sc_r));
        div_neg = sc_r[ACC_W-1];
      end
      OP_Q: begin
        div_num = {cov_r, {FRAC_BITS{1'b0}}};
        div_den = var_r;
      end
      OP_T: begin
        div_num = NW'(term_r);
        div_den = ACC_W'(count_r);
      end
      default: ;
    endcase
    div_res = div_neg ? -$signed(div_quo[ACC_W-1:0]) : $signed(div_quo[ACC_W-1:0]);
  end

  iat_div #(.NW(NW), .DW(ACC_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (accept && in_last) begin
          state_nxt = (n_after < CW'(2)) ? S_OUT : S_PASS;
        end
      end
      S_PASS: begin
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          unique case (op_r)
            OP_P, OP_B: state_nxt = S_DIVGO;
            OP_C:       state_nxt = S_MUL;
            OP_Q:       state_nxt = S_TERM;
            OP_T:       state_nxt = (t_r + CW'(1) < count_r) ? S_PASS : S_OUT;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_MUL:  state_nxt = S_COV;
      S_COV:  state_nxt = S_EVAL;
      S_EVAL: begin
        if (!cov_pos) begin
          state_nxt = S_OUT;
        end else if (t_r == '0) begin
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_DIVGO;
        end
      end
      S_TERM: state_nxt = S_DIVGO;
      S_OUT:  state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      t_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      v1_r        <= issue;
      v2_r        <= v1_r;
      prod_r      <= $signed(rx_r) * $signed(ry_r);
      xd_r        <= rx_r;
      yd_r        <= ry_r;
      if (issue) begin
        i_r <= i_r + CW'(1);
      end
      if (v2_r) begin
        if (psum[ACC_W] != psum[ACC_W-1]) begin
          p_r <= psum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          p_r <= psum[ACC_W-1:0];
        end
        sb_r <= sb_r + {{(ACC_W-SAMP_W){xd_r[SAMP_W-1]}}, xd_r};
        sc_r <= sc_r + {{(ACC_W-SAMP_W){yd_r[SAMP_W-1]}}, yd_r};
      end
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              count_r <= count_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            t_r       <= '0;
            i_r       <= '0;
            p_r       <= '0;
            sb_r      <= '0;
            sc_r      <= '0;
            tau_sum_r <= '0;
            var_r     <= '0;
          end
        end
        S_PASS: begin
          op_r <= OP_P;
        end
        S_DIVW: begin
          if (div_done) begin
            unique case (op_r)
              OP_P: begin
                a_r  <= div_res;
                op_r <= OP_B;
              end
              OP_B: begin
                b_r  <= div_res;
                op_r <= OP_C;
              end
              OP_C: c_r <= div_res;
              OP_Q: q_r <= (div_quo >= CAP_N) ? QW'(CAP_N) : div_quo[QW-1:0];
              OP_T: begin
                tau_sum_r <= tau_sum_r + div_quo[ACC_W-1:0];
                t_r       <= t_r + CW'(1);
                i_r       <= '0;
                p_r       <= '0;
                sb_r      <= '0;
                sc_r      <= '0;
              end
              default: ;
            endcase
          end
        end
        S_MUL: bc_r <= $signed(b_r[SAMP_W-1:0]) * $signed(c_r[SAMP_W-1:0]);
        S_COV: cov_r <= a_r - (bc_r >>> FRAC_BITS);
        S_EVAL: begin
          if (cov_pos) begin
            if (t_r == '0) begin
              var_r <= cov_r;
              t_r   <= CW'(1);
              i_r   <= '0;
              p_r   <= '0;
              sb_r  <= '0;
              sc_r  <= '0;
            end else begin
              op_r <= OP_Q;
            end
          end
        end
        S_TERM: begin
          term_r <= TW'(q_r) * TW'(count_r - t_r);
          op_r   <= OP_T;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_tau_r   <= (tau_full > TAU_MAX) ? {TAU_W{1'b1}} : tau_full[TAU_W-1:0];
          out_var_r   <= (var_r > $signed(VAR_MAX)) ? {VAR_W{1'b1}} : var_r[VAR_W-1:0];
          if (count_r < CW'(2)) begin
            out_stat_r <= STAT_SHORT;
          end else if (ovf_r) begin
            out_stat_r <= STAT_OVF;
          end else begin
            out_stat_r <= STAT_OK;
          end
          count_r <= '0;
          ovf_r   <= 1'b0;
          t_r     <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tau_int  = out_tau_r;
  assign out_variance = out_var_r;
  assign out_status   = out_stat_r;

  `IAT_ASSERT_NEXT(a_one_word, clk, rst_n, out_valid, !out_valid)
  `IAT_ASSERT_NEXT(a_last_busy, clk, rst_n, accept && in_last, busy)
  `IAT_ASSERT_NOW(a_short_tau, clk, rst_n, out_valid && (out_status == STAT_SHORT),
                  out_tau_int == TAU_W'(HALF) && out_variance == '0)
  `IAT_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(MAX_SAMPLES))
endmodule

// ----- dv/tb_top.sv -----
// Testbench for integrated_autocorrelation_time_core: streams sample series and
// checks tau, variance and status against a built-in predictor of the lag walk.
// Depends on iat_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import iat_pkg::*;

  localparam int NMAX = MAX_SAMPLES_DEF;
  localparam int FB   = FRAC_BITS_DEF;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [TAU_W-1:0]  tau;
    logic [VAR_W-1:0]  variance;
    logic [STAT_W-1:0] status;
  } iat_word_t;

  logic clk, rst_n, start, busy, in_last, out_valid;
  logic signed [SAMP_W-1:0] in_sample;
  logic [TAU_W-1:0]  out_tau_int;
  logic [VAR_W-1:0]  out_variance;
  logic [STAT_W-1:0] out_status;

  integrated_autocorrelation_time_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_last(in_last), .out_valid(out_valid),
    .out_tau_int(out_tau_int), .out_variance(out_variance), .out_status(out_status)
  );

  logic signed [SAMP_W-1:0] held_samples [0:NMAX-1];
  int unsigned held_count;
  bit          dropped_seen;
  iat_word_t   tau_expected [$];
  int          errors;
  bit          gaps_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint lag_autocov(int unsigned n, int unsigned t);
    longint p, sb, sc, x, y, prod, a, b, c;
    int unsigned m;
    p = 0; sb = 0; sc = 0;
    m = n - t;
    for (int unsigned i = 0; i < m; i++) begin
      x = longint'(held_samples[i]);
      y = longint'(held_samples[i + t]);
      prod = (x * y) >>> FB;
      if (prod > 0 && p > I64_MAX - prod) p = I64_MAX;
      else if (prod < 0 && p < I64_MIN - prod) p = I64_MIN;
      else p = p + prod;
      sb += x;
      sc += y;
    end
    a = p / longint'(m);
    b = sb / longint'(m);
    c = sc / longint'(m);
    return a - ((b * c) >>> FB);
  endfunction

  function automatic longint unsigned cov_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q, r, cap;
    cap = 64'd1 << CAP_LOG;
    q = num / den;
    r = num % den;
    if (q >= cap) return cap;
    for (int k = 0; k < FB; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
      if (q >= cap) return cap;
    end
    return q;
  endfunction

  // Updates the series state for one accepted word; queues a result on last.
  function automatic void predict_word(logic signed [SAMP_W-1:0] s, logic is_last);
    iat_word_t w;
    int unsigned n;
    longint vr, cv;
    longint unsigned tsum, tau;
    if (held_count < NMAX) begin
      held_samples[held_count] = s;
      held_count++;
    end else begin
      dropped_seen = 1;
    end
    if (!is_last) return;
    n = held_count;
    tsum = 0;
    w.variance = '0;
    if (n < 2) begin
      w.status = STAT_SHORT;
    end else begin
      vr = lag_autocov(n, 0);
      w.status = dropped_seen ? STAT_OVF : STAT_OK;
      if (vr > 0) begin
        w.variance = (vr > 64'sh0000_FFFF_FFFF_FFFF) ? {VAR_W{1'b1}} : vr[VAR_W-1:0];
        for (int unsigned t = 1; t < n; t++) begin
          cv = lag_autocov(n, t);
          if (cv <= 0) break;
          tsum += cov_ratio(cv, vr) * longint'(n - t) / longint'(n);
        end
      end
    end
    tau = (64'd1 << (FB - 1)) + tsum;
    w.tau = (tau > 64'hFFFF_FFFF) ? '1 : tau[TAU_W-1:0];
    tau_expected.insert(tau_expected.size(), w);
    held_count = 0;
    dropped_seen = 0;
  endfunction

  always @(posedge clk) begin
    iat_word_t w;
    if (rst_n && out_valid) begin
      if (tau_expected.size() == 0) begin
        $display("%0t: unexpected word tau=%h var=%h status=%0d", $time,
                 out_tau_int, out_variance, out_status);
        errors++;
      end else begin
        w = tau_expected.pop_front();
        if (out_tau_int !== w.tau) begin
          $display("%0t: tau expected %h actual %h", $time, w.tau, out_tau_int);
          errors++;
        end
        if (out_variance !== w.variance) begin
          $display("%0t: variance expected %h actual %h", $time, w.variance, out_variance);
          errors++;
        end
        if (out_status !== w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, w.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_word(logic signed [SAMP_W-1:0] s, logic is_last);
    idle_burst();
    start     <= 1;
    in_sample <= s;
    in_last   <= is_last;
    do @(posedge clk); while (busy);
    predict_word(s, is_last);
  endtask

  task automatic send_series(logic signed [SAMP_W-1:0] vals [$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (tau_expected.size() != 0) @(posedge clk);
  endtask

  // kind 0 full range, 1 small, 2 random walk, 3 constant
  function automatic logic signed [SAMP_W-1:0] pick_sample(int kind,
                                                            logic signed [SAMP_W-1:0] prev);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return prev + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0000_C000);
      default: return prev;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [SAMP_W-1:0] v [$];
    send_series('{32'sh0001_0000});
    send_series('{32'sh7FFF_FFFF, 32'sh8000_0000});
    send_series('{32'sh8000_0000, 32'sh8000_0000});
    send_series('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_series('{32'sh0, 32'sh0, 32'sh0});
    send_series('{32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000});
    v = {};
    for (int i = 0; i < 12; i++) v.insert(v.size(), i * 32'sh0001_0000);
    send_series(v);
  endtask

  task automatic test_drop_on_full();
    logic signed [SAMP_W-1:0] v [$];
    for (int i = 0; i < NMAX + 4; i++) v.insert(v.size(), $urandom);
    send_series(v);
  endtask

  task automatic test_random(int items, bit drain_each);
    logic signed [SAMP_W-1:0] v [$];
    logic signed [SAMP_W-1:0] prev;
    int sent, len, kind;
    sent = 0;
    gaps_on = 1;
    while (sent < items) begin
      if (sent > items * 3 / 4) gaps_on = 0;
      len = ($urandom_range(0, 30) == 0) ? $urandom_range(32, 80) : $urandom_range(1, 16);
      kind = $urandom_range(0, 9);
      kind = (kind < 3) ? 0 : (kind < 5) ? 1 : (kind < 9) ? 2 : 3;
      prev = pick_sample(1, 0);
      v = {};
      for (int i = 0; i < len; i++) begin
        prev = pick_sample(kind, prev);
        v.insert(v.size(), prev);
      end
      send_series(v);
      if (drain_each) wait_drained();
      sent += len;
    end
  endtask

  initial begin
    errors = 0;
    gaps_on = 1;
    held_count = 0;
    dropped_seen = 0;
    rst_n = 0;
    start = 0;
    in_sample = '0;
    in_last = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_drop_on_full();
    test_random(200, 1);
    test_random(1800, 0);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
